@@ hw/rtl/dqlu_pkg.sv @@
// Shared types, register codes and Q16.16 helpers for the double Q-learning update core.
package dqlu_pkg;

	// Q1.16 coefficients: 65536 is 1.0
	localparam int unsigned COEF_W   = 17;
	localparam logic [COEF_W-1:0] COEF_ONE = 17'h10000;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_LEARNING_RATE   = 1'd0;
	localparam cfg_idx_t REG_DISCOUNT_FACTOR = 1'd1;

	// datapath widths
	localparam int unsigned MUL_X_W = 36;	// multiplier data operand, signed
	localparam int unsigned PROD_W  = 54;	// full product, signed
	localparam int unsigned RND_W   = 38;	// product brought back to Q16.16
	localparam int unsigned SUM_W   = 39;	// table value plus change

	// request payloads, first field in the highest bits, last field in the lowest bits
	typedef struct packed {
		logic [4:0]         pad;
		logic signed [31:0] reward;
		logic [7:0]         next_state;
		logic [2:0]         taken_action;
		logic [7:0]         current_state;
	} in_tdata_t;

	typedef struct packed {
		logic [4:0]         pad;
		logic [2:0]         best_next_action;
		logic signed [31:0] updated_value;
	} out_tdata_t;

	typedef struct packed {
		logic saturated;
		logic updated_estimate;
	} out_tuser_t;

	function automatic logic [COEF_W-1:0] clamp_coef(input logic [COEF_W-1:0] v);
		return (v > COEF_ONE) ? COEF_ONE : v;
	endfunction

	// (p + 2^15) >> 16, floor on negatives
	function automatic logic signed [RND_W-1:0] q16_round(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] t;
		t = p + PROD_W'(32768);
		return t[PROD_W-1:16];
	endfunction

	function automatic logic sum_ovf(input logic signed [SUM_W-1:0] v);
		return (v > SUM_W'(64'sh7FFF_FFFF)) || (v < -SUM_W'(64'sh8000_0000));
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
		logic signed [31:0] r;
		if (v > SUM_W'(64'sh7FFF_FFFF)) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -SUM_W'(64'sh8000_0000)) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/double_q_learning_update_core.sv @@
// Double Q-learning update core: two Q16.16 tables (A and A+B) updated one transition at a time.
// A request is taken only in idle, so a new one waits until the previous result is in the
// output register; each update holds the row scan of the argmax (one table read per action)
// and the shared multiplier, used once for gamma, once for alpha.
// Reset: async, clears control and loads both coefficients with 1.0, then a clearing pass
// zeroes every entry of both tables, during which no request is taken.
module double_q_learning_update_core #(
	parameter int NUM_STATES  = 256,
	parameter int NUM_ACTIONS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  dqlu_pkg::cfg_idx_t    cfg_index,
	input  logic [16:0]           cfg_data,
	// transitions in
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  dqlu_pkg::in_tdata_t   s_axis_tdata,	// current_state, taken_action, next_state, reward
	input  logic                  s_axis_tuser,	// coin
	// results out
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output dqlu_pkg::out_tdata_t  m_axis_tdata,	// updated_value, best_next_action
	output dqlu_pkg::out_tuser_t  m_axis_tuser	// updated_estimate, saturated
);
	import dqlu_pkg::*;

	localparam int DEPTH = NUM_STATES * NUM_ACTIONS;
	localparam int AW    = $clog2(DEPTH);
	localparam int SW    = $clog2(NUM_STATES);
	localparam int ACW   = $clog2(NUM_ACTIONS);
	localparam int CW    = $clog2(NUM_ACTIONS + 1);

	// sequencer codes
	localparam logic [3:0] ST_CLEAR = 4'd0;	// zeroing sweep after reset
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_SCAN  = 4'd2;	// argmax over the next-state row
	localparam logic [3:0] ST_LOOK  = 4'd3;	// multiply by gamma
	localparam logic [3:0] ST_DIFF  = 4'd4;	// reward + look-ahead - current
	localparam logic [3:0] ST_MULA  = 4'd5;	// multiply by alpha
	localparam logic [3:0] ST_UPD   = 4'd6;	// round the change
	localparam logic [3:0] ST_WR    = 4'd7;	// write back the tables
	localparam logic [3:0] ST_FIN   = 4'd8;	// form result, load output register

	// index wrap by restoring subtraction, one compare per bit
	function automatic logic [SW-1:0] wrap_state(input logic [7:0] x);
		logic [31:0] t;
		t = 32'(x);
		for (int k = 7; k >= 0; k--) begin
			if (t >= (32'(NUM_STATES) << k)) begin
				t = t - (32'(NUM_STATES) << k);
			end
		end
		return t[SW-1:0];
	endfunction

	function automatic logic [ACW-1:0] wrap_action(input logic [2:0] x);
		logic [31:0] t;
		t = 32'(x);
		for (int k = 2; k >= 0; k--) begin
			if (t >= (32'(NUM_ACTIONS) << k)) begin
				t = t - (32'(NUM_ACTIONS) << k);
			end
		end
		return t[ACW-1:0];
	endfunction

	logic [3:0]                state_q;
	logic [AW-1:0]             clr_q;
	logic [CW-1:0]             idx_q;
	logic [AW-1:0]             cur_q;
	logic [AW-1:0]             row_q;
	logic                      coin_q;
	logic signed [31:0]        rew_q;
	logic [COEF_W-1:0]         alpha_q;
	logic [COEF_W-1:0]         gamma_q;

	// table storage
	logic signed [31:0]        mem_a [DEPTH];
	logic signed [31:0]        mem_s [DEPTH];
	logic signed [31:0]        rd_a_q;
	logic signed [31:0]        rd_s_q;
	logic [AW-1:0]             rd_addr;
	logic [AW-1:0]             wr_addr;
	logic                      a_we;
	logic                      s_we;
	logic signed [31:0]        a_wd;
	logic signed [31:0]        s_wd;

	// argmax tracking
	logic signed [32:0]        scan_v;
	logic signed [32:0]        best_v_q;
	logic [ACW-1:0]            best_i_q;
	logic signed [31:0]        best_a_q;
	logic signed [31:0]        best_s_q;
	logic signed [32:0]        best_b;

	// update datapath
	logic signed [31:0]        cur_a_q;
	logic signed [31:0]        cur_s_q;
	logic signed [MUL_X_W-1:0] mul_x;
	logic [COEF_W-1:0]         mul_k;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [RND_W-1:0]   look;
	logic signed [RND_W-1:0]   cur_v;
	logic signed [RND_W-1:0]   diff_q;
	logic signed [RND_W-1:0]   chg_q;
	logic signed [SUM_W-1:0]   sum_s;
	logic signed [SUM_W-1:0]   sum_a;
	logic signed [SUM_W-1:0]   b_res;
	logic signed [31:0]        news_q;
	logic signed [31:0]        newa_q;
	logic                      clip_q;
	logic [31:0]               best_wide;

	// output register
	logic                      out_valid_q;
	out_tdata_t                out_data_q;
	out_tuser_t                out_user_q;
	logic                      fin_go;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	// FIN waits for the output register to drain
	assign fin_go = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready);

	// configuration, coefficients above 1.0 act as 1.0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= COEF_ONE;
			gamma_q <= COEF_ONE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LEARNING_RATE:   alpha_q <= clamp_coef(cfg_data);
				REG_DISCOUNT_FACTOR: gamma_q <= clamp_coef(cfg_data);
			endcase
		end
	end

	// read address: row entries during the scan, then the current entry
	always_comb begin
		rd_addr = cur_q;
		if ((state_q == ST_SCAN) && (idx_q < CW'(NUM_ACTIONS))) begin
			rd_addr = row_q + AW'(idx_q);
		end
	end

	// write port: clearing sweep or write-back
	assign sum_s = SUM_W'(cur_s_q) + SUM_W'(chg_q);
	assign sum_a = SUM_W'(cur_a_q) + SUM_W'(chg_q);

	always_comb begin
		wr_addr = cur_q;
		a_we    = 1'b0;
		s_we    = 1'b0;
		a_wd    = sat32(sum_a);
		s_wd    = sat32(sum_s);
		if (state_q == ST_CLEAR) begin
			wr_addr = clr_q;
			a_we    = 1'b1;
			s_we    = 1'b1;
			a_wd    = '0;
			s_wd    = '0;
		end else if (state_q == ST_WR) begin
			a_we = coin_q;
			s_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (a_we) begin
			mem_a[wr_addr] <= a_wd;
		end
		if (s_we) begin
			mem_s[wr_addr] <= s_wd;
		end
		rd_a_q <= mem_a[rd_addr];
		rd_s_q <= mem_s[rd_addr];
	end

	// value compared in the scan: A on coin 1, B = sum - A on coin 0
	assign scan_v = coin_q ? 33'(rd_a_q) : (33'(rd_s_q) - 33'(rd_a_q));
	assign best_b = 33'(best_s_q) - 33'(best_a_q);

	// shared multiplier operands
	always_comb begin
		if (state_q == ST_MULA) begin
			mul_x = diff_q[MUL_X_W-1:0];
			mul_k = alpha_q;
		end else begin
			mul_x = coin_q ? MUL_X_W'(best_b) : MUL_X_W'(best_a_q);
			mul_k = gamma_q;
		end
	end

	assign look  = q16_round(prod_q);
	assign cur_v = coin_q ? RND_W'(cur_a_q) : RND_W'(33'(cur_s_q) - 33'(cur_a_q));
	assign b_res = SUM_W'(news_q) - SUM_W'(cur_a_q);
	assign best_wide = 32'(best_i_q);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					idx_q <= '0;
					if (s_axis_tvalid) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					idx_q <= idx_q + CW'(1);
					if (idx_q == CW'(NUM_ACTIONS)) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: state_q <= ST_DIFF;
				ST_DIFF: state_q <= ST_MULA;
				ST_MULA: state_q <= ST_UPD;
				ST_UPD:  state_q <= ST_WR;
				ST_WR:   state_q <= ST_FIN;
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cur_q  <= AW'(32'(wrap_state(s_axis_tdata.current_state)) * NUM_ACTIONS
				+ 32'(wrap_action(s_axis_tdata.taken_action)));
			row_q  <= AW'(32'(wrap_state(s_axis_tdata.next_state)) * NUM_ACTIONS);
			rew_q  <= s_axis_tdata.reward;
			coin_q <= s_axis_tuser;
		end
		// read data is registered, so it lags the address; strict > keeps the lowest index
		if ((state_q == ST_SCAN) && (idx_q != '0)) begin
			if ((idx_q == CW'(1)) || (scan_v > best_v_q)) begin
				best_v_q <= scan_v;
				best_i_q <= ACW'(idx_q - CW'(1));
				best_a_q <= rd_a_q;
				best_s_q <= rd_s_q;
			end
		end
		if (state_q == ST_LOOK) begin
			cur_a_q <= rd_a_q;
			cur_s_q <= rd_s_q;
		end
		if ((state_q == ST_LOOK) || (state_q == ST_MULA)) begin
			prod_q <= mul_x * $signed({1'b0, mul_k});
		end
		if (state_q == ST_DIFF) begin
			diff_q <= RND_W'(rew_q) + look - cur_v;
		end
		if (state_q == ST_UPD) begin
			chg_q <= look;
		end
		if (state_q == ST_WR) begin
			news_q <= sat32(sum_s);
			newa_q <= sat32(sum_a);
			clip_q <= sum_ovf(sum_s) | (coin_q & sum_ovf(sum_a));
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			out_data_q.pad              <= '0;
			out_data_q.best_next_action <= best_wide[2:0];
			out_data_q.updated_value    <= coin_q ? newa_q : sat32(b_res);
			out_user_q.updated_estimate <= !coin_q;
			out_user_q.saturated        <= clip_q | (!coin_q & sum_ovf(b_res));
		end
	end

	// no request is taken before the tables are cleared
	a_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !s_axis_tready)
		else $error("request taken during clearing pass");

	// A is written only by the sweep or a coin 1 write-back
	a_a_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		a_we |-> ((state_q == ST_CLEAR) || ((state_q == ST_WR) && coin_q)))
		else $error("unexpected write to table A");

	// results come only out of the final step
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_FIN))
		else $error("result appeared outside the final step");

	// scan counter stays within the row plus the current-entry read
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (idx_q <= CW'(NUM_ACTIONS)))
		else $error("scan counter past the row");

	// a pending result is never overwritten
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |-> !fin_go)
		else $error("pending result overwritten");

endmodule
